// File: rtl/ctc_pkg.sv
// shared constants, types and helpers for the converter telemetry conditioner
package ctc_pkg;

	// field and register widths
	localparam int CODE_W     = 12;
	localparam int REG_W      = 12;
	localparam int REG_ADDR_W = 3;
	localparam int VAL_W      = 14;
	localparam int MASK_W     = 5;
	localparam int VOLT_W     = 13;
	localparam int MV_W       = 12;
	localparam int LANE_IN_W  = 15;
	localparam int PROD_W     = 27;
	localparam int Q_W        = 18;

	localparam int IN_TDATA_W  = 64;
	localparam int OUT_TDATA_W = 72;

	// filter and sense settings
	localparam int FILTER_SHIFT_DEF = 2;
	localparam int SAMPLE_BITS      = 12;

	// scaling constants
	localparam logic [12:0]       VSCALE_NUM    = 13'd6800;
	localparam int                VSCALE_SHIFT  = 12;
	localparam logic [11:0]       SENSE_FULL_MV = 12'd3300;
	localparam logic [PROD_W-1:0] GAIN_RND      = PROD_W'(500);
	localparam int                RECIP_SHIFT   = 37;
	localparam int                RECIP_W       = 28;
	// ceil(2^37 / 1000): exact floor division by 1000 for every 27-bit dividend
	localparam logic [RECIP_W-1:0] GAIN_RECIP =
		RECIP_W'(((64'd1 << RECIP_SHIFT) / 64'd1000) + 64'd1);
	localparam logic [VAL_W-1:0]  SAT_MAX        = 14'd9999;
	localparam logic [VAL_W-1:0]  IIN_HOLD       = 14'd4;
	localparam logic [Q_W:0]      IO_OFFSET_BUCK = (Q_W+1)'(2);

	// register reset values
	localparam logic [REG_W-1:0] CURRENT_ZERO_RST   = 12'd1640;
	localparam logic [REG_W-1:0] IX_GAIN_BOOST_RST  = 12'd1135;
	localparam logic [REG_W-1:0] IY_GAIN_BOOST_RST  = 12'd1376;
	localparam logic [REG_W-1:0] IX_GAIN_BUCK_RST   = 12'd1080;
	localparam logic [REG_W-1:0] IY_GAIN_BUCK_RST   = 12'd1360;
	localparam logic [REG_W-1:0] VTAR_GAIN_BOOST_RST = 12'd998;
	localparam logic [REG_W-1:0] VTAR_GAIN_BUCK_RST = 12'd995;
	localparam logic [REG_W-1:0] IO_REFIT_BUCK_RST  = 12'd964;

	// register indexes
	localparam logic [REG_ADDR_W-1:0] REG_CURRENT_ZERO    = 3'd0;
	localparam logic [REG_ADDR_W-1:0] REG_IX_GAIN_BOOST   = 3'd1;
	localparam logic [REG_ADDR_W-1:0] REG_IY_GAIN_BOOST   = 3'd2;
	localparam logic [REG_ADDR_W-1:0] REG_IX_GAIN_BUCK    = 3'd3;
	localparam logic [REG_ADDR_W-1:0] REG_IY_GAIN_BUCK    = 3'd4;
	localparam logic [REG_ADDR_W-1:0] REG_VTAR_GAIN_BOOST = 3'd5;
	localparam logic [REG_ADDR_W-1:0] REG_VTAR_GAIN_BUCK  = 3'd6;
	localparam logic [REG_ADDR_W-1:0] REG_IO_REFIT_BUCK   = 3'd7;

	typedef struct packed {
		logic load;
		logic conv;
		logic filt;
	} front_ctrl_t;

	typedef struct packed {
		logic [VOLT_W-1:0] vt;
		logic [VOLT_W-1:0] vx;
		logic [VOLT_W-1:0] vy;
		logic [MV_W-1:0]   dx;
		logic [MV_W-1:0]   dy;
	} front_res_t;

	function automatic logic [VAL_W-1:0] sat_val(input logic [Q_W:0] v);
		logic [VAL_W-1:0] r;
		r = (v > (Q_W+1)'(SAT_MAX)) ? SAT_MAX : v[VAL_W-1:0];
		return r;
	endfunction

endpackage

// File: rtl/converter_telemetry_conditioner.sv
// sequence: each item passes conversion, filter update and a first gain pass; buck items
//   then take a second pass of the output current through the y gain lane, and the merge
//   waits for a free output register; a new item is taken only after the last is merged
// a finished result waits in the output register while the next item is taken
// reset: arst_n clears the sequencer, filters, change history and loads register defaults
module converter_telemetry_conditioner #(
	parameter int FILTER_SHIFT = ctc_pkg::FILTER_SHIFT_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// configuration write port
	input  logic                                  cfg_we,
	input  logic [ctc_pkg::REG_ADDR_W-1:0]        cfg_addr,
	input  logic [ctc_pkg::REG_W-1:0]             cfg_wdata,
	// input beat
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	// target_code[11:0], vx_code[23:12], vy_code[35:24], ix_sample[47:36],
	// iy_sample[59:48], zero fill[63:60]
	input  logic [ctc_pkg::IN_TDATA_W-1:0]        s_tdata,
	// boost_mode[0]
	input  logic                                  s_tuser,
	// result beat
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	// vin_value[13:0], vout_value[27:14], vtarget_value[41:28], iin_value[55:42],
	// iout_value[69:56], zero fill[71:70]
	output logic [ctc_pkg::OUT_TDATA_W-1:0]       m_tdata,
	// changed_mask[4:0]
	output logic [ctc_pkg::MASK_W-1:0]            m_tuser
);
	import ctc_pkg::*;

	// sequencer codes
	localparam logic [2:0] ST_IDLE  = 3'd0;  // waiting for a beat
	localparam logic [2:0] ST_CONV  = 3'd1;  // voltage scaling and sense conversion
	localparam logic [2:0] ST_FILT  = 3'd2;  // filter update and zero distance
	localparam logic [2:0] ST_G1    = 3'd3;  // first pass through the gain lanes
	localparam logic [2:0] ST_G1W   = 3'd4;
	localparam logic [2:0] ST_G2    = 3'd5;  // buck refit pass on the y lane
	localparam logic [2:0] ST_G2W   = 3'd6;
	localparam logic [2:0] ST_MERGE = 3'd7;  // combine lanes into the output register

	logic [2:0] state_q, state_nxt;
	logic       boost_q;

	// configuration registers
	logic [REG_W-1:0] current_zero_q, ix_gain_boost_q, iy_gain_boost_q, ix_gain_buck_q;
	logic [REG_W-1:0] iy_gain_buck_q, vtar_gain_boost_q, vtar_gain_buck_q, io_refit_buck_q;

	front_ctrl_t      front_ctrl;
	front_res_t       front_res;

	logic                 in_beat, merge_load, lane_en, lane_y_en, second_pass;
	logic [LANE_IN_W-1:0] lane_y_v;
	logic [REG_W-1:0]     lane_vt_g, lane_x_g, lane_y_g;
	logic [Q_W-1:0]       q_vt, q_ix, q_iy;

	assign s_tready = (state_q == ST_IDLE);
	assign in_beat  = s_tvalid && s_tready;

	// the output register frees up when empty or when its beat is taken
	assign merge_load = (state_q == ST_MERGE) && (!m_tvalid || m_tready);

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE:  if (in_beat) state_nxt = ST_CONV;
			ST_CONV:  state_nxt = ST_FILT;
			ST_FILT:  state_nxt = ST_G1;
			ST_G1:    state_nxt = ST_G1W;
			ST_G1W:   state_nxt = boost_q ? ST_MERGE : ST_G2;
			ST_G2:    state_nxt = ST_G2W;
			ST_G2W:   state_nxt = ST_MERGE;
			ST_MERGE: if (merge_load) state_nxt = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (in_beat) begin
			boost_q <= s_tuser;
		end
	end

	// register writes, no read-back
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			current_zero_q    <= CURRENT_ZERO_RST;
			ix_gain_boost_q   <= IX_GAIN_BOOST_RST;
			iy_gain_boost_q   <= IY_GAIN_BOOST_RST;
			ix_gain_buck_q    <= IX_GAIN_BUCK_RST;
			iy_gain_buck_q    <= IY_GAIN_BUCK_RST;
			vtar_gain_boost_q <= VTAR_GAIN_BOOST_RST;
			vtar_gain_buck_q  <= VTAR_GAIN_BUCK_RST;
			io_refit_buck_q   <= IO_REFIT_BUCK_RST;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_CURRENT_ZERO:    current_zero_q    <= cfg_wdata;
				REG_IX_GAIN_BOOST:   ix_gain_boost_q   <= cfg_wdata;
				REG_IY_GAIN_BOOST:   iy_gain_boost_q   <= cfg_wdata;
				REG_IX_GAIN_BUCK:    ix_gain_buck_q    <= cfg_wdata;
				REG_IY_GAIN_BUCK:    iy_gain_buck_q    <= cfg_wdata;
				REG_VTAR_GAIN_BOOST: vtar_gain_boost_q <= cfg_wdata;
				REG_VTAR_GAIN_BUCK:  vtar_gain_buck_q  <= cfg_wdata;
				REG_IO_REFIT_BUCK:   io_refit_buck_q   <= cfg_wdata;
			endcase
		end
	end

	// front end: scaling, filters, zero distance
	assign front_ctrl.load = in_beat;
	assign front_ctrl.conv = (state_q == ST_CONV);
	assign front_ctrl.filt = (state_q == ST_FILT);

	ctc_front #(
		.FILTER_SHIFT(FILTER_SHIFT)
	) u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.ctrl           (front_ctrl),
		.target_code    (s_tdata[CODE_W-1:0]),
		.vx_code        (s_tdata[2*CODE_W-1:CODE_W]),
		.vy_code        (s_tdata[3*CODE_W-1:2*CODE_W]),
		.ix_sample      (s_tdata[4*CODE_W-1:3*CODE_W]),
		.iy_sample      (s_tdata[5*CODE_W-1:4*CODE_W]),
		.current_zero_mv(current_zero_q),
		.res            (front_res)
	);

	// three gain lanes side by side: target voltage, x current, y current
	assign lane_en     = (state_q == ST_G1) || (state_q == ST_G1W);
	assign second_pass = (state_q == ST_G2);
	assign lane_y_en   = lane_en || second_pass || (state_q == ST_G2W);

	assign lane_vt_g = boost_q ? vtar_gain_boost_q : vtar_gain_buck_q;
	assign lane_x_g  = boost_q ? ix_gain_boost_q : ix_gain_buck_q;
	// buck refit feeds the first y result back through the same lane
	assign lane_y_g  = boost_q ? iy_gain_boost_q :
		(second_pass ? io_refit_buck_q : iy_gain_buck_q);
	assign lane_y_v  = second_pass ? q_iy[LANE_IN_W-1:0] : LANE_IN_W'(front_res.dy);

	ctc_lane u_lane_vt (
		.clk(clk),
		.en (lane_en),
		.v  (LANE_IN_W'(front_res.vt)),
		.g  (lane_vt_g),
		.q  (q_vt)
	);

	ctc_lane u_lane_x (
		.clk(clk),
		.en (lane_en),
		.v  (LANE_IN_W'(front_res.dx)),
		.g  (lane_x_g),
		.q  (q_ix)
	);

	ctc_lane u_lane_y (
		.clk(clk),
		.en (lane_y_en),
		.v  (lane_y_v),
		.g  (lane_y_g),
		.q  (q_iy)
	);

	// merge: saturate, map sides, hold input current, mark changes
	ctc_merge u_merge (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    (merge_load),
		.boost   (boost_q),
		.q_vt    (q_vt),
		.q_ix    (q_ix),
		.q_iy    (q_iy),
		.vx      (front_res.vx),
		.vy      (front_res.vy),
		.m_tready(m_tready),
		.m_tvalid(m_tvalid),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser)
	);

`ifndef ASSERT_OFF
	// a result beat only appears out of the merge step
	a_valid_from_merge: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> ($past(state_q) == ST_MERGE))
		else $error("result beat raised outside the merge step");

	// one item at a time: no second beat straight after an accepted one
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("input taken while an item is in flight");

	// buck items always take the refit pass
	a_buck_refit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_G1W && !boost_q) |=> (state_q == ST_G2))
		else $error("buck item skipped the refit pass");

	// every reported value lies within the saturation limit
	a_saturated: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[13:0] <= SAT_MAX && m_tdata[27:14] <= SAT_MAX &&
			m_tdata[41:28] <= SAT_MAX && m_tdata[55:42] <= SAT_MAX &&
			m_tdata[69:56] <= SAT_MAX))
		else $error("result value above saturation limit");
`endif

endmodule

// File: rtl/ctc_front.sv
// front end: voltage scaling, sense conversion, current filters and zero distance
module ctc_front #(
	parameter int FILTER_SHIFT = ctc_pkg::FILTER_SHIFT_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  ctc_pkg::front_ctrl_t      ctrl,
	input  logic [ctc_pkg::CODE_W-1:0] target_code,
	input  logic [ctc_pkg::CODE_W-1:0] vx_code,
	input  logic [ctc_pkg::CODE_W-1:0] vy_code,
	input  logic [ctc_pkg::CODE_W-1:0] ix_sample,
	input  logic [ctc_pkg::CODE_W-1:0] iy_sample,
	input  logic [ctc_pkg::REG_W-1:0]  current_zero_mv,
	output ctc_pkg::front_res_t       res
);
	import ctc_pkg::*;

	localparam int ACC_W = MV_W + FILTER_SHIFT;
	localparam int VP_W  = CODE_W + 13;
	localparam int MVP_W = SAMPLE_BITS + 13;
	localparam logic [MVP_W-1:0] MV_RND = MVP_W'(1) << (SAMPLE_BITS - 1);

	logic [CODE_W-1:0] target_q, vx_q, vy_q, ix_q, iy_q;
	logic [MV_W-1:0]   mvx_q, mvy_q;
	logic [ACC_W-1:0]  acc_x_q, acc_y_q;
	logic              seeded_q;
	front_res_t        res_q;

	logic [VP_W-1:0]   vt_prod, vx_prod, vy_prod;
	logic [MVP_W-1:0]  mvx_prod, mvy_prod;
	logic [ACC_W:0]    acc_x_upd, acc_y_upd;
	logic [ACC_W-1:0]  acc_x_nxt, acc_y_nxt;
	logic [MV_W-1:0]   fx, fy, dx, dy;

	assign vt_prod = VP_W'(target_q) * VP_W'(VSCALE_NUM);
	assign vx_prod = VP_W'(vx_q) * VP_W'(VSCALE_NUM);
	assign vy_prod = VP_W'(vy_q) * VP_W'(VSCALE_NUM);

	assign mvx_prod = MVP_W'(ix_q[SAMPLE_BITS-1:0]) * MVP_W'(SENSE_FULL_MV) + MV_RND;
	assign mvy_prod = MVP_W'(iy_q[SAMPLE_BITS-1:0]) * MVP_W'(SENSE_FULL_MV) + MV_RND;

	// quarter-weight style filter, seeded by the first beat
	assign acc_x_upd = {1'b0, acc_x_q} + (ACC_W+1)'(mvx_q)
		- (ACC_W+1)'(acc_x_q >> FILTER_SHIFT);
	assign acc_y_upd = {1'b0, acc_y_q} + (ACC_W+1)'(mvy_q)
		- (ACC_W+1)'(acc_y_q >> FILTER_SHIFT);
	assign acc_x_nxt = seeded_q ? acc_x_upd[ACC_W-1:0] : (ACC_W'(mvx_q) << FILTER_SHIFT);
	assign acc_y_nxt = seeded_q ? acc_y_upd[ACC_W-1:0] : (ACC_W'(mvy_q) << FILTER_SHIFT);

	assign fx = acc_x_nxt[FILTER_SHIFT +: MV_W];
	assign fy = acc_y_nxt[FILTER_SHIFT +: MV_W];
	assign dx = (fx >= current_zero_mv) ? fx - current_zero_mv : current_zero_mv - fx;
	assign dy = (fy >= current_zero_mv) ? fy - current_zero_mv : current_zero_mv - fy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_x_q  <= '0;
			acc_y_q  <= '0;
			seeded_q <= 1'b0;
		end else if (ctrl.filt) begin
			acc_x_q  <= acc_x_nxt;
			acc_y_q  <= acc_y_nxt;
			seeded_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			target_q <= target_code;
			vx_q     <= vx_code;
			vy_q     <= vy_code;
			ix_q     <= ix_sample;
			iy_q     <= iy_sample;
		end
		if (ctrl.conv) begin
			res_q.vt <= vt_prod[VSCALE_SHIFT +: VOLT_W];
			res_q.vx <= vx_prod[VSCALE_SHIFT +: VOLT_W];
			res_q.vy <= vy_prod[VSCALE_SHIFT +: VOLT_W];
			mvx_q    <= mvx_prod[SAMPLE_BITS +: MV_W];
			mvy_q    <= mvy_prod[SAMPLE_BITS +: MV_W];
		end
		if (ctrl.filt) begin
			res_q.dx <= dx;
			res_q.dy <= dy;
		end
	end

	assign res = res_q;

endmodule

// File: rtl/ctc_lane.sv
// gain lane: rounded multiply by a gain in thousandths, two stages
module ctc_lane (
	input  logic                          clk,
	input  logic                          en,
	input  logic [ctc_pkg::LANE_IN_W-1:0] v,
	input  logic [ctc_pkg::REG_W-1:0]     g,
	output logic [ctc_pkg::Q_W-1:0]       q
);
	import ctc_pkg::*;

	localparam int FULL_W = PROD_W + RECIP_W;

	logic [PROD_W-1:0] p_s1;
	logic [Q_W-1:0]    q_s2;
	logic [FULL_W-1:0] recip_prod;

	// divide by 1000 through the exact reciprocal
	assign recip_prod = FULL_W'(p_s1) * FULL_W'(GAIN_RECIP);

	always_ff @(posedge clk) begin
		if (en) begin
			p_s1 <= PROD_W'(v) * PROD_W'(g) + GAIN_RND;
			q_s2 <= recip_prod[RECIP_SHIFT +: Q_W];
		end
	end

	assign q = q_s2;

endmodule

// File: rtl/ctc_merge.sv
// merge stage: saturation, side mapping, input current hold, change mask, output register
module ctc_merge (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                load,
	input  logic                                boost,
	input  logic [ctc_pkg::Q_W-1:0]             q_vt,
	input  logic [ctc_pkg::Q_W-1:0]             q_ix,
	input  logic [ctc_pkg::Q_W-1:0]             q_iy,
	input  logic [ctc_pkg::VOLT_W-1:0]          vx,
	input  logic [ctc_pkg::VOLT_W-1:0]          vy,
	input  logic                                m_tready,
	output logic                                m_tvalid,
	output logic [ctc_pkg::OUT_TDATA_W-1:0]     m_tdata,
	output logic [ctc_pkg::MASK_W-1:0]          m_tuser
);
	import ctc_pkg::*;

	logic [VAL_W-1:0] vt_s, ix_s, iy_s, vin, vout, iin_c, iin, iout, diff;
	logic             hold;
	logic [MASK_W-1:0] mask;

	logic [VAL_W-1:0] prev_vt_q, prev_vin_q, prev_vout_q, prev_iin_q, prev_iout_q;
	logic             prev_valid_q;
	logic             valid_q;
	logic [OUT_TDATA_W-1:0] data_q;
	logic [MASK_W-1:0] user_q;

	assign vt_s = sat_val({1'b0, q_vt});
	assign ix_s = sat_val({1'b0, q_ix});
	assign iy_s = boost ? sat_val({1'b0, q_iy}) : sat_val({1'b0, q_iy} + IO_OFFSET_BUCK);

	assign vin   = boost ? VAL_W'(vy) : VAL_W'(vx);
	assign vout  = boost ? VAL_W'(vx) : VAL_W'(vy);
	assign iin_c = boost ? iy_s : ix_s;
	assign iout  = boost ? ix_s : iy_s;

	assign diff = (iin_c > prev_iin_q) ? iin_c - prev_iin_q : prev_iin_q - iin_c;
	assign hold = prev_valid_q && (diff <= IIN_HOLD);
	assign iin  = hold ? prev_iin_q : iin_c;

	assign mask[0] = !prev_valid_q || (vt_s != prev_vt_q);
	assign mask[1] = !prev_valid_q || (vin != prev_vin_q);
	assign mask[2] = !prev_valid_q || (vout != prev_vout_q);
	assign mask[3] = !prev_valid_q || (iin != prev_iin_q);
	assign mask[4] = !prev_valid_q || (iout != prev_iout_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q      <= 1'b0;
			prev_valid_q <= 1'b0;
		end else begin
			if (load) begin
				valid_q      <= 1'b1;
				prev_valid_q <= 1'b1;
			end else if (m_tready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			prev_vt_q   <= vt_s;
			prev_vin_q  <= vin;
			prev_vout_q <= vout;
			prev_iin_q  <= iin;
			prev_iout_q <= iout;
			data_q      <= {2'b00, iout, iin, vt_s, vout, vin};
			user_q      <= mask;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = data_q;
	assign m_tuser  = user_q;

endmodule
